// ----- hw/rtl/cltla_pkg.sv -----
package cltla_pkg;

   // default geometry
   localparam int GRID_MAX_DEF    = 33;
   localparam int ENTRY_WIDTH_DEF = 16;

   // stream payload widths
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 32;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   localparam logic [CSR_IDX_W-1:0] CSR_ONE_D_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_SIZE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INTENSITY  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DOMAIN_MIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DOMAIN_MAX = 3'd4;

   localparam logic [47:0] DOMAIN_MAX_RST = 48'h1000_1000_1000;
   localparam logic [12:0] INTENSITY_FULL = 13'd4096;

   // item kinds carried on req_tuser
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_PIXEL = 1'b1;

   // long division: one quotient bit per cycle
   localparam int DIV_STEPS = 32;

   // corner reads per pixel
   localparam logic [2:0] RD_LAST_3D = 3'd7;
   localparam logic [2:0] RD_LAST_1D = 3'd5;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOC,
      ST_DINIT,
      ST_DIV,
      ST_IDX,
      ST_ADR,
      ST_ADR2,
      ST_READ,
      ST_RWAIT,
      ST_LERP,
      ST_BL1,
      ST_BL2,
      ST_FIN
   } ctrl_state_type;

   // interpolation step sequence
   typedef enum logic [2:0] {
      LS_X0,
      LS_X1,
      LS_X2,
      LS_X3,
      LS_Y0,
      LS_Y1,
      LS_Z,
      LS_1D
   } lerp_step_type;

   typedef struct packed {
      logic          accept;
      logic          loc;
      logic          dinit;
      logic          div;
      logic          idx;
      logic          adr;
      logic          adr2;
      logic          rd_en;
      logic [2:0]    rd_idx;
      logic          lerp_en;
      lerp_step_type lerp_step;
      logic          bl1;
      logic          bl2;
      logic          commit;
   } dp_cmd_type;

   typedef struct packed {
      logic pass;
      logic one_d;
   } dp_stat_type;

endpackage

// ----- hw/rtl/color_lut_trilinear_apply_core.sv -----
// Color lookup table applied to RGBA pixels, trilinear 3D or per-channel 1D.
// req channel: req_tuser selects the item kind (0 load a table entry,
// 1 process a pixel); req_tdata carries entry and pixel fields. A load is
// written to the table at its accept edge when its index lies inside the
// table and gives no result; loads are taken one per cycle while idle. A
// pixel gives exactly one rsp item. A pass-through pixel goes from accept
// straight to commit; otherwise 3D mode does 8 corner reads and 7 lerp
// steps and 1D mode 6 reads and 1 lerp step, and the long division that
// locates each channel on its axis takes most of the time. One pixel is
// worked on at a time: the next item is accepted once the last pixel is
// committed to the output register, also while the result waits there;
// a finished pixel holds until rsp_tready frees that register.
// Configuration is written through csr_we/csr_index/csr_wdata only while
// idle, a rule for the user that the core does not enforce. Reset
// (synchronous) restores the register defaults and empties the output;
// table contents are undefined until loaded and no clearing pass is run.
module color_lut_trilinear_apply_core #(
   parameter int GRID_MAX    = cltla_pkg::GRID_MAX_DEF,
   parameter int ENTRY_WIDTH = cltla_pkg::ENTRY_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [cltla_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cltla_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // entry_index, entry_red, entry_green, entry_blue,
   // pixel_red, pixel_green, pixel_blue, pixel_alpha
   input  logic [cltla_pkg::REQ_DATA_W-1:0] req_tdata,
   // opcode
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // out_red, out_green, out_blue, out_alpha
   output logic [cltla_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import cltla_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   cltla_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .cmd        (cmd)
   );

   cltla_dp #(
      .GRID_MAX    (GRID_MAX),
      .ENTRY_WIDTH (ENTRY_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_tdata (rsp_tdata)
   );

   // a pixel that is accepted keeps the input closed the next cycle
   a_pixel_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == OP_PIXEL) |=> !req_tready)
      else $error("input open right after a pixel item");

   // a committed result shows up as valid
   a_commit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_tvalid)
      else $error("committed result not presented");

   // output empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

// ----- hw/rtl/cltla_ctrl.sv -----
module cltla_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tuser,
   input  logic                  rsp_tready,
   input  cltla_pkg::dp_stat_type stat,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   output cltla_pkg::dp_cmd_type cmd
);
   import cltla_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic [4:0]     cnt_ff, cnt_in;
   lerp_step_type  step_ff, step_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [2:0]     rd_last;

   assign rd_last = stat.one_d ? RD_LAST_1D : RD_LAST_3D;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tuser == OP_PIXEL) begin
               state_in = stat.pass ? ST_FIN : ST_LOC;
            end
         end
         ST_LOC:   state_in = ST_DINIT;
         ST_DINIT: state_in = ST_DIV;
         ST_DIV: begin
            if (cnt_ff == 5'(DIV_STEPS - 1)) state_in = ST_IDX;
         end
         ST_IDX:   state_in = stat.one_d ? ST_READ : ST_ADR;
         ST_ADR:   state_in = ST_ADR2;
         ST_ADR2:  state_in = ST_READ;
         ST_READ: begin
            if (cnt_ff[2:0] == rd_last) state_in = ST_RWAIT;
         end
         ST_RWAIT: state_in = ST_LERP;
         ST_LERP: begin
            if (step_ff == LS_Z || step_ff == LS_1D) state_in = ST_BL1;
         end
         ST_BL1:   state_in = ST_BL2;
         ST_BL2:   state_in = ST_FIN;
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs and commands
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      cmd.rd_idx    = cnt_ff[2:0];
      cmd.lerp_step = step_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_LOC:   cmd.loc     = 1'b1;
         ST_DINIT: cmd.dinit   = 1'b1;
         ST_DIV:   cmd.div     = 1'b1;
         ST_IDX:   cmd.idx     = 1'b1;
         ST_ADR:   cmd.adr     = 1'b1;
         ST_ADR2:  cmd.adr2    = 1'b1;
         ST_READ:  cmd.rd_en   = 1'b1;
         ST_LERP:  cmd.lerp_en = 1'b1;
         ST_BL1:   cmd.bl1     = 1'b1;
         ST_BL2:   cmd.bl2     = 1'b1;
         ST_FIN:   cmd.commit  = !rsp_valid_ff || rsp_tready;
         default:  cmd = '0;
      endcase
   end

   // counters and output valid
   always_comb begin
      cnt_in  = (state_ff == ST_DIV || state_ff == ST_READ) ? cnt_ff + 5'd1 : 5'd0;
      if (state_ff == ST_LERP) begin
         step_in = lerp_step_type'(step_ff + 3'd1);
      end else begin
         step_in = stat.one_d ? LS_1D : LS_X0;
      end
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         step_ff      <= LS_X0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ----- hw/rtl/cltla_dp.sv -----
module cltla_dp #(
   parameter int GRID_MAX    = cltla_pkg::GRID_MAX_DEF,
   parameter int ENTRY_WIDTH = cltla_pkg::ENTRY_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [cltla_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cltla_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic [cltla_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                                req_tuser,
   input  cltla_pkg::dp_cmd_type               cmd,
   output cltla_pkg::dp_stat_type              stat,
   output logic [cltla_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import cltla_pkg::*;

   localparam int TABLE_DEPTH = GRID_MAX * GRID_MAX * GRID_MAX;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int MEM_W       = 3 * ENTRY_WIDTH;

   // configuration registers
   logic        one_d_ff;
   logic [15:0] size_ff;
   logic [12:0] inten_ff;
   logic [47:0] dmin_ff, dmax_ff;

   // pixel capture
   logic [7:0] px_ff [3];
   logic [7:0] alpha_ff;
   logic       pass_ff;

   // locate and divide, per channel
   logic signed [15:0] lo_c [3];
   logic signed [15:0] hi_c [3];
   logic signed [26:0] num_c [3];
   logic signed [26:0] span_c [3];
   logic signed [26:0] den_c [3];
   logic [40:0] numn_ff [3], numn_in [3];
   logic [24:0] den_ff [3], den_in [3];
   logic        le_ff [3], le_in [3];
   logic        ge_ff [3], ge_in [3];
   logic [25:0] rem_ff [3], rem_in [3];
   logic [31:0] sh_ff [3], sh_in [3];
   logic [31:0] q_ff [3], q_in [3];
   logic [25:0] trial_c [3];
   logic [31:0] x_c [3];
   logic [16:0] inc_c [3];
   logic [15:0] i0_ff [3], i0_in [3];
   logic [15:0] i1_ff [3], i1_in [3];
   logic [15:0] f_ff [3], f_in [3];

   // address terms
   logic [15:0]       n_c;
   logic [ADDR_W-1:0] ss_ff, ss_in, y0s_ff, y0s_in, y1s_ff, y1s_in;
   logic [ADDR_W-1:0] z0s_ff, z0s_in, z1s_ff, z1s_in;
   logic [ADDR_W-1:0] rd_addr, mem_addr;

   // table memory
   logic [MEM_W-1:0]  mem [TABLE_DEPTH];
   logic [MEM_W-1:0]  mem_q_ff, mem_wd;
   logic              mem_we;
   logic signed [23:0] wr_ext [3];
   logic signed [23:0] ext_q [3];
   logic signed [31:0] cell_q [3];
   logic              rdv_ff;
   logic [2:0]        rdi_ff;

   // corners and interpolation
   logic signed [31:0] corner_ff [8][3];
   logic signed [31:0] corner_in [8][3];
   logic signed [31:0] acc_ff [4][3];
   logic signed [31:0] acc_in [4][3];
   logic signed [31:0] lp_a [3], lp_b [3];
   logic [15:0]        lp_f [3];
   logic [1:0]         lp_dst;
   logic signed [32:0] lp_d [3];
   logic signed [16:0] lp_fs [3];
   logic signed [49:0] lp_prod [3];
   logic signed [31:0] lp_res [3];

   // blend
   logic [12:0]        k_c;
   logic signed [13:0] ks_c;
   logic signed [41:0] bd_c [3];
   logic signed [55:0] prod_ff [3], prod_in [3];
   logic signed [57:0] tot_c [3];
   logic signed [17:0] rs_c [3];
   logic [7:0]         res_ff [3], res_in [3];
   logic [7:0]         out_ff [3];
   logic [7:0]         out_alpha_ff;

   logic over_c, dom_bad_c, pass_c;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         one_d_ff <= 1'b0;
         size_ff  <= '0;
         inten_ff <= INTENSITY_FULL;
         dmin_ff  <= '0;
         dmax_ff  <= DOMAIN_MAX_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ONE_D_MODE: one_d_ff <= csr_wdata[0];
            CSR_TABLE_SIZE: size_ff  <= csr_wdata[15:0];
            CSR_INTENSITY:  inten_ff <= csr_wdata[12:0];
            CSR_DOMAIN_MIN: dmin_ff  <= csr_wdata;
            CSR_DOMAIN_MAX: dmax_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pass-through decision
   always_comb begin
      k_c       = (inten_ff > INTENSITY_FULL) ? INTENSITY_FULL : inten_ff;
      ks_c      = signed'({1'b0, k_c});
      n_c       = size_ff - 16'd1;
      dom_bad_c = 1'b0;
      for (int c = 0; c < 3; c++) begin
         lo_c[c] = signed'(dmin_ff[16*c +: 16]);
         hi_c[c] = signed'(dmax_ff[16*c +: 16]);
         if (hi_c[c] <= lo_c[c]) dom_bad_c = 1'b1;
      end
      over_c = one_d_ff ? (32'(size_ff) > 32'(TABLE_DEPTH))
                        : (32'(size_ff) > 32'(GRID_MAX));
      pass_c = (req_tdata[95:88] == 8'd0) || (size_ff == 16'd0) ||
               (k_c == 13'd0) || over_c || dom_bad_c;
   end

   assign stat.pass  = pass_c;
   assign stat.one_d = one_d_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pass_ff  <= pass_c;
         alpha_ff <= req_tdata[95:88];
         for (int c = 0; c < 3; c++) px_ff[c] <= req_tdata[64 + 8*c +: 8];
      end
   end

   // locate, long division and grid index
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         num_c[c]  = 27'(signed'({1'b0, px_ff[c], 12'd0}))
                   - ((27'(lo_c[c]) <<< 8) - 27'(lo_c[c]));
         span_c[c] = 27'(hi_c[c]) - 27'(lo_c[c]);
         den_c[c]  = (span_c[c] <<< 8) - span_c[c];

         numn_in[c] = numn_ff[c];
         den_in[c]  = den_ff[c];
         le_in[c]   = le_ff[c];
         ge_in[c]   = ge_ff[c];
         if (cmd.loc) begin
            numn_in[c] = 41'(num_c[c][24:0]) * 41'(n_c);
            den_in[c]  = den_c[c][24:0];
            le_in[c]   = num_c[c] <= 27'sd0;
            ge_in[c]   = num_c[c] >= den_c[c];
         end

         trial_c[c] = {rem_ff[c][24:0], sh_ff[c][31]};
         rem_in[c]  = rem_ff[c];
         sh_in[c]   = sh_ff[c];
         q_in[c]    = q_ff[c];
         if (cmd.dinit) begin
            rem_in[c] = {1'b0, numn_ff[c][40:16]};
            sh_in[c]  = {numn_ff[c][15:0], 16'd0};
            q_in[c]   = '0;
         end else if (cmd.div) begin
            sh_in[c] = {sh_ff[c][30:0], 1'b0};
            if (trial_c[c] >= {1'b0, den_ff[c]}) begin
               rem_in[c] = trial_c[c] - {1'b0, den_ff[c]};
               q_in[c]   = {q_ff[c][30:0], 1'b1};
            end else begin
               rem_in[c] = trial_c[c];
               q_in[c]   = {q_ff[c][30:0], 1'b0};
            end
         end

         if (le_ff[c]) begin
            x_c[c] = '0;
         end else if (ge_ff[c]) begin
            x_c[c] = {n_c, 16'd0};
         end else begin
            x_c[c] = q_ff[c];
         end
         inc_c[c] = 17'(x_c[c][31:16]) + 17'd1;
         i0_in[c] = i0_ff[c];
         i1_in[c] = i1_ff[c];
         f_in[c]  = f_ff[c];
         if (cmd.idx) begin
            i0_in[c] = x_c[c][31:16];
            f_in[c]  = x_c[c][15:0];
            i1_in[c] = (inc_c[c] < 17'(n_c)) ? inc_c[c][15:0] : n_c;
         end
      end
   end

   // cube address terms
   always_comb begin
      ss_in  = cmd.adr  ? ADDR_W'(size_ff) * ADDR_W'(size_ff)  : ss_ff;
      y0s_in = cmd.adr  ? ADDR_W'(i0_ff[1]) * ADDR_W'(size_ff) : y0s_ff;
      y1s_in = cmd.adr  ? ADDR_W'(i1_ff[1]) * ADDR_W'(size_ff) : y1s_ff;
      z0s_in = cmd.adr2 ? ADDR_W'(i0_ff[2]) * ss_ff            : z0s_ff;
      z1s_in = cmd.adr2 ? ADDR_W'(i1_ff[2]) * ss_ff            : z1s_ff;
   end

   always_ff @(posedge clock) begin
      numn_ff <= numn_in;
      den_ff  <= den_in;
      le_ff   <= le_in;
      ge_ff   <= ge_in;
      rem_ff  <= rem_in;
      sh_ff   <= sh_in;
      q_ff    <= q_in;
      i0_ff   <= i0_in;
      i1_ff   <= i1_in;
      f_ff    <= f_in;
      ss_ff   <= ss_in;
      y0s_ff  <= y0s_in;
      y1s_ff  <= y1s_in;
      z0s_ff  <= z0s_in;
      z1s_ff  <= z1s_in;
   end

   // corner address: 1D reads low/high entry per channel, 3D walks the cube
   always_comb begin
      if (one_d_ff) begin
         rd_addr = cmd.rd_idx[0] ? ADDR_W'(i1_ff[cmd.rd_idx[2:1]])
                                 : ADDR_W'(i0_ff[cmd.rd_idx[2:1]]);
      end else begin
         rd_addr = (cmd.rd_idx[0] ? ADDR_W'(i1_ff[0]) : ADDR_W'(i0_ff[0]))
                 + (cmd.rd_idx[1] ? y1s_ff : y0s_ff)
                 + (cmd.rd_idx[2] ? z1s_ff : z0s_ff);
      end
   end

   // table load: wrap entries to the stored width
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         wr_ext[c] = 24'(signed'(req_tdata[16 + 16*c +: 16]));
         mem_wd[c*ENTRY_WIDTH +: ENTRY_WIDTH] = wr_ext[c][ENTRY_WIDTH-1:0];
      end
      mem_we   = cmd.accept && (req_tuser == OP_LOAD) &&
                 (32'(req_tdata[15:0]) < 32'(TABLE_DEPTH));
      mem_addr = mem_we ? ADDR_W'(req_tdata[15:0]) : rd_addr;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wd;
      end else if (cmd.rd_en) begin
         mem_q_ff <= mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rdv_ff <= 1'b0;
      end else begin
         rdv_ff <= cmd.rd_en;
      end
      rdi_ff <= cmd.rd_idx;
   end

   // read data to 2^-28 scale, captured into corners
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         ext_q[c]  = 24'(signed'(mem_q_ff[c*ENTRY_WIDTH +: ENTRY_WIDTH]));
         cell_q[c] = signed'({ext_q[c][15:0], 16'd0});
      end
      corner_in = corner_ff;
      if (rdv_ff) begin
         if (one_d_ff) begin
            corner_in[{2'b00, rdi_ff[0]}][rdi_ff[2:1]] = cell_q[rdi_ff[2:1]];
         end else begin
            for (int c = 0; c < 3; c++) corner_in[rdi_ff][c] = cell_q[c];
         end
      end
   end

   // one lerp unit per channel, stepped through x, y, z in 3D mode, a single step in 1D mode
   always_comb begin
      lp_dst = 2'd0;
      case (cmd.lerp_step)
         LS_X0, LS_X1, LS_X2, LS_X3: lp_dst = cmd.lerp_step[1:0];
         LS_Y1:                      lp_dst = 2'd2;
         default:                    lp_dst = 2'd0;
      endcase
      for (int c = 0; c < 3; c++) begin
         case (cmd.lerp_step)
            LS_X0, LS_X1, LS_X2, LS_X3: begin
               lp_a[c] = corner_ff[{cmd.lerp_step[1:0], 1'b0}][c];
               lp_b[c] = corner_ff[{cmd.lerp_step[1:0], 1'b1}][c];
               lp_f[c] = f_ff[0];
            end
            LS_Y0: begin
               lp_a[c] = acc_ff[0][c];
               lp_b[c] = acc_ff[1][c];
               lp_f[c] = f_ff[1];
            end
            LS_Y1: begin
               lp_a[c] = acc_ff[2][c];
               lp_b[c] = acc_ff[3][c];
               lp_f[c] = f_ff[1];
            end
            LS_Z: begin
               lp_a[c] = acc_ff[0][c];
               lp_b[c] = acc_ff[2][c];
               lp_f[c] = f_ff[2];
            end
            default: begin
               lp_a[c] = corner_ff[0][c];
               lp_b[c] = corner_ff[1][c];
               lp_f[c] = f_ff[c];
            end
         endcase
         lp_d[c]    = 33'(lp_b[c]) - 33'(lp_a[c]);
         lp_fs[c]   = signed'({1'b0, lp_f[c]});
         lp_prod[c] = lp_d[c] * lp_fs[c];
         lp_res[c]  = 32'(34'(lp_a[c]) + 34'(lp_prod[c] >>> 16));
      end
      acc_in = acc_ff;
      if (cmd.lerp_en) begin
         for (int c = 0; c < 3; c++) acc_in[lp_dst][c] = lp_res[c];
      end
   end

   // blend with input, round half up, clamp
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         bd_c[c] = ((42'(acc_ff[0][c]) <<< 8) - 42'(acc_ff[0][c]))
                 - 42'(signed'({1'b0, px_ff[c], 28'd0}));
         prod_in[c] = cmd.bl1 ? bd_c[c] * ks_c : prod_ff[c];
         tot_c[c] = 58'(prod_ff[c]) + 58'(signed'({1'b0, px_ff[c], 40'd0}))
                  + 58'(signed'({2'b01, 39'd0}));
         rs_c[c]  = 18'(tot_c[c] >>> 40);
         if (!cmd.bl2) begin
            res_in[c] = res_ff[c];
         end else if (rs_c[c] < 18'sd0) begin
            res_in[c] = 8'd0;
         end else if (rs_c[c] > 18'sd255) begin
            res_in[c] = 8'd255;
         end else begin
            res_in[c] = rs_c[c][7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      corner_ff <= corner_in;
      acc_ff    <= acc_in;
      prod_ff   <= prod_in;
      res_ff    <= res_in;
      if (cmd.commit) begin
         out_alpha_ff <= alpha_ff;
         for (int c = 0; c < 3; c++) out_ff[c] <= pass_ff ? px_ff[c] : res_ff[c];
      end
   end

   assign rsp_tdata = {out_alpha_ff, out_ff[2], out_ff[1], out_ff[0]};

endmodule

// ----- tb/color_lut_checker.sv -----
// Watches the csr port and both streams, predicts each pixel result and
// compares it with what the core returns.
module color_lut_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [cltla_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cltla_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [cltla_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                             req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [cltla_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                               errors,
   output int                               pending,
   output int                               pixels_seen,
   output int                               loads_seen
);
   import cltla_pkg::*;

   localparam int GRID  = GRID_MAX_DEF;
   localparam int DEPTH = GRID * GRID * GRID;

   // shadow copy of the lookup table and the registers
   logic signed [15:0] lut_mem [0:DEPTH-1][0:2];
   bit          one_d;
   bit   [15:0] tsize;
   bit   [12:0] inten;
   bit   [47:0] dmin;
   bit   [47:0] dmax;

   logic [31:0] pixel_queue [$];

   function automatic longint corner(int unsigned idx, int c);
      return longint'(lut_mem[idx][c]) * 65536;
   endfunction

   function automatic longint lerp(longint a, longint b, int unsigned f);
      return a + (((b - a) * longint'(f)) >>> 16);
   endfunction

   // expected out_red/green/blue/alpha for one pixel item
   function automatic logic [31:0] shade_pixel(logic [95:0] d);
      int unsigned px [3];
      int unsigned i0 [3];
      int unsigned i1 [3];
      int unsigned fr [3];
      int          lo [3];
      int          hi [3];
      longint      lut [3];
      longint      num, den, x, total, r, c00, c10, c01, c11, c0, c1;
      int unsigned s, n, k, ss, y0, y1, z0, z1;
      logic [7:0]  alpha;
      logic [7:0]  res [3];
      bit          pass;
      for (int c = 0; c < 3; c++) begin
         px[c] = d[64 + 8*c +: 8];
         lo[c] = int'($signed(dmin[16*c +: 16]));
         hi[c] = int'($signed(dmax[16*c +: 16]));
      end
      alpha = d[95:88];
      s = tsize;
      k = (inten > 4096) ? 4096 : inten;
      pass = (alpha == 0) || (s == 0) || (k == 0);
      if (one_d ? (s > DEPTH) : (s > GRID)) pass = 1;
      for (int c = 0; c < 3; c++)
         if (hi[c] <= lo[c]) pass = 1;
      if (pass)
         return {alpha, d[87:80], d[79:72], d[71:64]};

      n = s - 1;
      // position on each axis, fraction in Q0.16
      for (int c = 0; c < 3; c++) begin
         num = longint'(px[c]) * 4096 - 255 * longint'(lo[c]);
         den = 255 * (longint'(hi[c]) - longint'(lo[c]));
         if (num <= 0) x = 0;
         else if (num >= den) x = longint'(n) << 16;
         else x = (num * longint'(n) * 65536) / den;
         i0[c] = int'(x >> 16);
         fr[c] = int'(x & 64'hFFFF);
         i1[c] = (i0[c] + 1 < n) ? i0[c] + 1 : n;
      end

      if (one_d) begin
         for (int c = 0; c < 3; c++)
            lut[c] = lerp(corner(i0[c], c), corner(i1[c], c), fr[c]);
      end else begin
         ss = s * s;
         y0 = i0[1] * s;
         y1 = i1[1] * s;
         z0 = i0[2] * ss;
         z1 = i1[2] * ss;
         for (int c = 0; c < 3; c++) begin
            c00 = lerp(corner(i0[0] + y0 + z0, c), corner(i1[0] + y0 + z0, c), fr[0]);
            c10 = lerp(corner(i0[0] + y1 + z0, c), corner(i1[0] + y1 + z0, c), fr[0]);
            c01 = lerp(corner(i0[0] + y0 + z1, c), corner(i1[0] + y0 + z1, c), fr[0]);
            c11 = lerp(corner(i0[0] + y1 + z1, c), corner(i1[0] + y1 + z1, c), fr[0]);
            c0 = lerp(c00, c10, fr[1]);
            c1 = lerp(c01, c11, fr[1]);
            lut[c] = lerp(c0, c1, fr[2]);
         end
      end

      // blend by intensity, round half up, clamp
      for (int c = 0; c < 3; c++) begin
         total = longint'(px[c]) * (longint'(1) << 40)
               + (lut[c] * 255 - longint'(px[c]) * (longint'(1) << 28)) * longint'(k);
         r = (total + (longint'(1) << 39)) >>> 40;
         if (r < 0) r = 0;
         if (r > 255) r = 255;
         res[c] = r[7:0];
      end
      return {alpha, res[2], res[1], res[0]};
   endfunction

   always @(posedge clock) begin
      logic [31:0] want;
      logic [15:0] idx;
      if (reset) begin
         one_d = 0;
         tsize = 0;
         inten = INTENSITY_FULL;
         dmin = '0;
         dmax = DOMAIN_MAX_RST;
         pixel_queue.delete();
         errors = 0;
         pixels_seen = 0;
         loads_seen = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ONE_D_MODE: one_d = csr_wdata[0];
               CSR_TABLE_SIZE: tsize = csr_wdata[15:0];
               CSR_INTENSITY:  inten = csr_wdata[12:0];
               CSR_DOMAIN_MIN: dmin = csr_wdata[47:0];
               CSR_DOMAIN_MAX: dmax = csr_wdata[47:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == OP_LOAD) begin
               idx = req_tdata[15:0];
               loads_seen++;
               // out-of-range addresses are dropped
               if (idx < DEPTH)
                  for (int c = 0; c < 3; c++)
                     lut_mem[idx][c] = req_tdata[16 + 16*c +: 16];
            end else begin
               pixel_queue.push_back(shade_pixel(req_tdata));
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pixel_queue.size() == 0) begin
               $error("unexpected result %h", rsp_tdata);
               errors++;
            end else begin
               want = pixel_queue.pop_front();
               pixels_seen++;
               if (rsp_tdata[7:0] !== want[7:0]) begin
                  $error("out_red expected %0d got %0d", want[7:0], rsp_tdata[7:0]);
                  errors++;
               end
               if (rsp_tdata[15:8] !== want[15:8]) begin
                  $error("out_green expected %0d got %0d", want[15:8], rsp_tdata[15:8]);
                  errors++;
               end
               if (rsp_tdata[23:16] !== want[23:16]) begin
                  $error("out_blue expected %0d got %0d", want[23:16], rsp_tdata[23:16]);
                  errors++;
               end
               if (rsp_tdata[31:24] !== want[31:24]) begin
                  $error("out_alpha expected %0d got %0d", want[31:24], rsp_tdata[31:24]);
                  errors++;
               end
            end
         end
      end
      pending = pixel_queue.size();
   end

endmodule

// ----- tb/tb.sv -----
module tb;
   import cltla_pkg::*;

   localparam int DEPTH = GRID_MAX_DEF * GRID_MAX_DEF * GRID_MAX_DEF;
   // loaded low corner of the table: a cube of EDGE points per axis
   localparam int EDGE  = 6;
   localparam int USED  = EDGE * EDGE * EDGE;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  csr_we = 0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_tvalid = 0;
   logic                  req_tready;
   // entry_index, entry_red, entry_green, entry_blue,
   // pixel_red, pixel_green, pixel_blue, pixel_alpha
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // opcode
   logic                  req_tuser = 0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 0;
   // out_red, out_green, out_blue, out_alpha
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int errors, pending, pixels_seen, loads_seen, settings;
   bit quiet = 1;
   bit long_hold = 0;

   always #4 clock = ~clock;

   color_lut_trilinear_apply_core dut (.*);

   color_lut_checker chk (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .errors, .pending, .pixels_seen, .loads_seen
   );

   // pack three Q4.12 bounds, red lowest
   function automatic logic [47:0] dom(int r, int g, int b);
      return {16'(b), 16'(g), 16'(r)};
   endfunction

   task automatic send(logic op, logic [95:0] d);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= d;
      req_tuser  <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic load(int idx, int r, int g, int b);
      send(OP_LOAD, {$urandom(), 16'(b), 16'(g), 16'(r), 16'(idx)});
   endtask

   task automatic pixel(int r, int g, int b, int a);
      send(OP_PIXEL, {8'(a), 8'(b), 8'(g), 8'(r), $urandom(), $urandom()});
   endtask

   // table values: mostly within 0..1, sometimes the full signed range
   function automatic int entry_val();
      return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 65535))
                                         : int'($urandom_range(0, 4096));
   endfunction

   function automatic int chan();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 255;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   // wait for the core to drain, then rewrite every register
   task automatic set_cfg(bit one_d, int size, int inten, logic [47:0] lo, logic [47:0] hi);
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      csr_we <= 1; csr_index <= CSR_ONE_D_MODE; csr_wdata <= 48'(one_d);
      @(posedge clock);
      csr_index <= CSR_TABLE_SIZE; csr_wdata <= 48'(size);
      @(posedge clock);
      csr_index <= CSR_INTENSITY; csr_wdata <= 48'(inten);
      @(posedge clock);
      csr_index <= CSR_DOMAIN_MIN; csr_wdata <= lo;
      @(posedge clock);
      csr_index <= CSR_DOMAIN_MAX; csr_wdata <= hi;
      @(posedge clock);
      csr_we <= 0;
      settings++;
   endtask

   // receiver: random hold-offs, one long stall on request
   initial begin
      forever begin
         if (long_hold) begin
            rsp_tready <= 0;
            repeat (400) @(posedge clock);
            long_hold = 0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp_tready <= 1;
            @(posedge clock);
         end
      end
   end

   initial begin
      #(8 * 3000000);
      $display("color_lut_trilinear_apply_core: mismatch");
      $finish;
   end

   initial begin
      bit          one_d;
      int          size, inten, lo_r, lo_g, lo_b;
      logic [47:0] lo, hi;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset state: no table, pixels pass
      pixel(10, 20, 30, 40);

      // define the low corner and the last entry; every lookup stays inside them
      for (int i = 0; i < USED; i++)
         load(i, entry_val(), entry_val(), entry_val());
      load(DEPTH - 1, entry_val(), entry_val(), entry_val());

      set_cfg(0, 2, 4096, '0, DOMAIN_MAX_RST);
      pixel(0, 0, 0, 255);
      pixel(255, 255, 255, 255);
      pixel(128, 64, 200, 1);
      pixel(90, 90, 90, 0);
      load(0, 32767, -32768, 0);
      pixel(0, 0, 0, 9);
      load(65535, 1, 2, 3);
      load(DEPTH, 4, 5, 6);
      set_cfg(0, 2, 0, '0, DOMAIN_MAX_RST);
      pixel(100, 150, 200, 77);
      set_cfg(0, 2, 8191, '0, DOMAIN_MAX_RST);
      pixel(100, 150, 200, 77);
      set_cfg(0, 2, 2048, '0, DOMAIN_MAX_RST);
      pixel(100, 150, 200, 77);
      set_cfg(0, 2, 4096, dom(0, 4096, 0), DOMAIN_MAX_RST);
      pixel(100, 150, 200, 77);
      set_cfg(0, 1, 4096, '0, DOMAIN_MAX_RST);
      pixel(100, 150, 200, 77);
      // full-size tables: white lands on the last entry; one size more passes through
      set_cfg(0, 33, 4096, '0, DOMAIN_MAX_RST);
      pixel(255, 255, 255, 200);
      set_cfg(0, 34, 4096, '0, DOMAIN_MAX_RST);
      pixel(255, 0, 128, 200);
      set_cfg(1, DEPTH, 4096, '0, DOMAIN_MAX_RST);
      pixel(255, 255, 255, 200);
      set_cfg(1, DEPTH + 1, 4096, '0, DOMAIN_MAX_RST);
      pixel(255, 0, 128, 200);
      set_cfg(1, 2, 4096, dom(-4096, -32768, 2000), dom(32767, 4096, 2001));
      pixel(255, 0, 128, 200);

      // random settings; the last two phases run without idling
      quiet = 0;
      for (int ph = 0; ph < 14; ph++) begin
         one_d = $urandom_range(0, 1);
         case ($urandom_range(0, 9))
            0: size = 0;
            1: size = 1;
            2: size = one_d ? DEPTH + $urandom_range(1, 3) : 34;
            3: size = one_d ? USED : EDGE;
            4: size = one_d ? $urandom_range(DEPTH + 1, 65535)
                            : $urandom_range(GRID_MAX_DEF + 1, 65535);
            default: size = one_d ? $urandom_range(2, USED) : $urandom_range(2, EDGE);
         endcase
         case ($urandom_range(0, 5))
            0: inten = $urandom_range(0, 8191);
            1: inten = $urandom_range(0, 4096);
            default: inten = 4096;
         endcase
         if ($urandom_range(0, 6) == 0) begin
            lo = {$urandom(), $urandom()};
            hi = {$urandom(), $urandom()};
         end else begin
            lo_r = $urandom_range(0, 4096) - 2048;
            lo_g = $urandom_range(0, 4096) - 2048;
            lo_b = $urandom_range(0, 4096) - 2048;
            lo = dom(lo_r, lo_g, lo_b);
            hi = dom(lo_r + $urandom_range(1, 8192), lo_g + $urandom_range(1, 8192),
                     lo_b + $urandom_range(1, 8192));
         end
         if (ph == 12) quiet = 1;
         set_cfg(one_d, size, inten, lo, hi);
         if (ph == 3) long_hold = 1;
         for (int i = 0; i < 55; i++) begin
            if ($urandom_range(0, 6) == 0) begin
               // rewrites keep every entry defined; some addresses miss the table
               load(($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                 : $urandom_range(0, USED - 1),
                    entry_val(), entry_val(), entry_val());
            end else begin
               pixel(chan(), chan(), chan(),
                     ($urandom_range(0, 9) == 0) ? 0 : chan());
            end
         end
      end
      req_tvalid <= 0;

      // drain
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("covered %0d pixel results and %0d table loads across %0d register settings",
               pixels_seen, loads_seen, settings);
      $display("3D and 1D lookups, pass-through cases, intensity extremes, long output stall");
      if (errors == 0)
         $display("color_lut_trilinear_apply_core: match");
      else
         $display("color_lut_trilinear_apply_core: mismatch");
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/cltla_pkg.sv
hw/rtl/cltla_ctrl.sv
hw/rtl/cltla_dp.sv
hw/rtl/color_lut_trilinear_apply_core.sv
tb/color_lut_checker.sv
tb/tb.sv
